// ===== sv/format_spec_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Format spec parser assertion macros
// Shorthand for clocked concurrent checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPEC_PARSER_ASSERT_SVH
`define FORMAT_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication: ante |-> cons
`define FSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("format_spec_parser: same-cycle check failed");

// Next-cycle implication: ante |=> cons
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("format_spec_parser: next-cycle check failed");

`endif

// ===== sv/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Format spec parser package
// Shared character codes, modifier codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsp_pkg;

    localparam int NUMBER_BITS_DEFAULT = 16;
    localparam int NUM_OUT_W           = 16;
    localparam int CHAR_W              = 8;
    localparam int MOD_W               = 3;

    // Characters recognized by the parser
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_LOW_H = 8'h68;
    localparam logic [CHAR_W-1:0] CHAR_LOW_L = 8'h6C;
    localparam logic [CHAR_W-1:0] CHAR_UP_L  = 8'h4C;

    // Flag bit positions
    localparam int FB_PLUS  = 0;
    localparam int FB_SPACE = 1;
    localparam int FB_MINUS = 2;
    localparam int FB_ZERO  = 3;
    localparam int FB_HASH  = 4;
    localparam int FLAG_W   = 5;

    // Length modifier codes
    localparam logic [MOD_W-1:0] MOD_NONE = 3'd0;
    localparam logic [MOD_W-1:0] MOD_H    = 3'd1;
    localparam logic [MOD_W-1:0] MOD_HH   = 3'd2;
    localparam logic [MOD_W-1:0] MOD_L    = 3'd3;
    localparam logic [MOD_W-1:0] MOD_LL   = 3'd4;
    localparam logic [MOD_W-1:0] MOD_BIGL = 3'd5;

    typedef struct packed {
        logic                 flag_plus;
        logic                 flag_space;
        logic                 flag_minus;
        logic                 flag_zero;
        logic                 flag_hash;
        logic [NUM_OUT_W-1:0] field_width;
        logic                 has_precision;
        logic [NUM_OUT_W-1:0] precision_value;
        logic [MOD_W-1:0]     length_modifier;
        logic [CHAR_W-1:0]    conversion;
    } spec_t;

    typedef struct packed {
        logic  emit;
        spec_t spec;
    } core_out_t;

endpackage

// ===== sv/fsp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Format spec parser stream interfaces
// Valid/ready channels for input characters and parsed specifiers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fsp_char_if;
    logic                        valid;
    logic                        ready;
    logic [fsp_pkg::CHAR_W-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface fsp_spec_if;
    logic                           valid;
    logic                           ready;
    logic                           flag_plus;
    logic                           flag_space;
    logic                           flag_minus;
    logic                           flag_zero;
    logic                           flag_hash;
    logic [fsp_pkg::NUM_OUT_W-1:0]  field_width;
    logic                           has_precision;
    logic [fsp_pkg::NUM_OUT_W-1:0]  precision_value;
    logic [fsp_pkg::MOD_W-1:0]      length_modifier;
    logic [fsp_pkg::CHAR_W-1:0]     conversion;

    modport source (output valid, output flag_plus, output flag_space, output flag_minus,
                    output flag_zero, output flag_hash, output field_width,
                    output has_precision, output precision_value,
                    output length_modifier, output conversion, input ready);
    modport sink   (input valid, input flag_plus, input flag_space, input flag_minus,
                    input flag_zero, input flag_hash, input field_width,
                    input has_precision, input precision_value,
                    input length_modifier, input conversion, output ready);
endinterface

// ===== sv/fsp_core.sv =====
// ----------------------------------------------------------------------------
// Format spec parser core
// Parse state registers and the per-character next-state and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsp_core #(
    parameter int NUMBER_BITS = fsp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [fsp_pkg::CHAR_W-1:0]  character,
    output fsp_pkg::core_out_t          core_out
);

    localparam int ACC_W = (NUMBER_BITS < fsp_pkg::NUM_OUT_W) ? NUMBER_BITS
                                                               : fsp_pkg::NUM_OUT_W;

    localparam logic [2:0] PH_FLAGS    = 3'd0;
    localparam logic [2:0] PH_WIDTH    = 3'd1;
    localparam logic [2:0] PH_DOT      = 3'd2;
    localparam logic [2:0] PH_PREC     = 3'd3;
    localparam logic [2:0] PH_MOD_H    = 3'd4;
    localparam logic [2:0] PH_MOD_L    = 3'd5;
    localparam logic [2:0] PH_MOD_DONE = 3'd6;

    logic [2:0]                   phase_reg, phase_next;
    logic [fsp_pkg::FLAG_W-1:0]   flags_reg, flags_next;
    logic [ACC_W-1:0]             width_reg, width_next;
    logic                         dot_reg, dot_next;
    logic [ACC_W-1:0]             prec_reg, prec_next;
    logic [fsp_pkg::MOD_W-1:0]    mod_reg, mod_next;

    logic                         is_digit;
    logic [3:0]                   digit;
    logic                         is_flag;
    logic [fsp_pkg::FLAG_W-1:0]   flag_mask;
    logic                         mod_or_conv;
    logic                         emit;
    logic [fsp_pkg::MOD_W-1:0]    conv_mod;

    // acc * 10 + d, held at all ones on overflow
    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [ACC_W+3:0] ext;
        logic [ACC_W+3:0] sum;
        ext = {4'b0000, acc};
        sum = (ext << 3) + (ext << 1) + {{ACC_W{1'b0}}, d};
        if (sum[ACC_W+3:ACC_W] != 4'b0000)
            return {ACC_W{1'b1}};
        return sum[ACC_W-1:0];
    endfunction

    assign is_digit = (character >= fsp_pkg::CHAR_ZERO) && (character <= fsp_pkg::CHAR_NINE);
    assign digit    = 4'(character - fsp_pkg::CHAR_ZERO);

    always_comb
    begin
        flag_mask = '0;
        case (character)
            fsp_pkg::CHAR_PLUS:  flag_mask[fsp_pkg::FB_PLUS]  = 1'b1;
            fsp_pkg::CHAR_SPACE: flag_mask[fsp_pkg::FB_SPACE] = 1'b1;
            fsp_pkg::CHAR_MINUS: flag_mask[fsp_pkg::FB_MINUS] = 1'b1;
            fsp_pkg::CHAR_ZERO:  flag_mask[fsp_pkg::FB_ZERO]  = 1'b1;
            fsp_pkg::CHAR_HASH:  flag_mask[fsp_pkg::FB_HASH]  = 1'b1;
            default:             flag_mask = '0;
        endcase
    end

    assign is_flag = (flag_mask != '0);

    always_comb
    begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        width_next  = width_reg;
        dot_next    = dot_reg;
        prec_next   = prec_reg;
        mod_next    = mod_reg;
        mod_or_conv = 1'b0;
        emit        = 1'b0;
        conv_mod    = mod_reg;

        unique case (phase_reg) inside
            PH_FLAGS, PH_WIDTH:
            begin
                if (phase_reg == PH_FLAGS && is_flag)
                    flags_next = flags_reg | flag_mask;
                else if (is_digit)
                begin
                    width_next = add_digit(width_reg, digit);
                    phase_next = PH_WIDTH;
                end
                else if (character == fsp_pkg::CHAR_DOT)
                begin
                    dot_next   = 1'b1;
                    prec_next  = ACC_W'(1);
                    phase_next = PH_DOT;
                end
                else
                    mod_or_conv = 1'b1;
            end
            PH_DOT:
            begin
                if (is_digit)
                begin
                    prec_next  = ACC_W'(digit);
                    phase_next = PH_PREC;
                end
                else
                    mod_or_conv = 1'b1;
            end
            PH_PREC:
            begin
                if (is_digit)
                    prec_next = add_digit(prec_reg, digit);
                else
                    mod_or_conv = 1'b1;
            end
            PH_MOD_H:
            begin
                if (character == fsp_pkg::CHAR_LOW_H)
                begin
                    mod_next   = fsp_pkg::MOD_HH;
                    phase_next = PH_MOD_DONE;
                end
                else
                begin
                    conv_mod = fsp_pkg::MOD_H;
                    emit     = 1'b1;
                end
            end
            PH_MOD_L:
            begin
                if (character == fsp_pkg::CHAR_LOW_L)
                begin
                    mod_next   = fsp_pkg::MOD_LL;
                    phase_next = PH_MOD_DONE;
                end
                else
                begin
                    conv_mod = fsp_pkg::MOD_L;
                    emit     = 1'b1;
                end
            end
            default:
                emit = 1'b1;
        endcase

        if (mod_or_conv)
        begin
            if (character == fsp_pkg::CHAR_LOW_H)
                phase_next = PH_MOD_H;
            else if (character == fsp_pkg::CHAR_LOW_L)
                phase_next = PH_MOD_L;
            else if (character == fsp_pkg::CHAR_UP_L)
            begin
                mod_next   = fsp_pkg::MOD_BIGL;
                phase_next = PH_MOD_DONE;
            end
            else
                emit = 1'b1;
        end

        // Conversion byte ends the specifier: return to the start state
        if (emit)
        begin
            phase_next = PH_FLAGS;
            flags_next = '0;
            width_next = '0;
            dot_next   = 1'b0;
            prec_next  = '0;
            mod_next   = fsp_pkg::MOD_NONE;
        end
    end

    always_comb
    begin
        core_out.emit                 = emit;
        core_out.spec.flag_plus       = flags_reg[fsp_pkg::FB_PLUS];
        core_out.spec.flag_space      = flags_reg[fsp_pkg::FB_SPACE]
                                        & ~flags_reg[fsp_pkg::FB_PLUS];
        core_out.spec.flag_minus      = flags_reg[fsp_pkg::FB_MINUS];
        core_out.spec.flag_zero       = flags_reg[fsp_pkg::FB_ZERO]
                                        & ~flags_reg[fsp_pkg::FB_MINUS];
        core_out.spec.flag_hash       = flags_reg[fsp_pkg::FB_HASH];
        core_out.spec.field_width     = fsp_pkg::NUM_OUT_W'(width_reg);
        core_out.spec.has_precision   = dot_reg;
        core_out.spec.precision_value = dot_reg ? fsp_pkg::NUM_OUT_W'(prec_reg) : '0;
        core_out.spec.length_modifier = conv_mod;
        core_out.spec.conversion      = character;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAGS;
            flags_reg <= '0;
            width_reg <= '0;
            dot_reg   <= 1'b0;
            prec_reg  <= '0;
            mod_reg   <= fsp_pkg::MOD_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            width_reg <= width_next;
            dot_reg   <= dot_next;
            prec_reg  <= prec_next;
            mod_reg   <= mod_next;
        end
    end

endmodule

// ===== sv/format_spec_parser.sv =====
// ----------------------------------------------------------------------------
// Format spec parser
// Streaming parser for a printf-style conversion specifier.
// ----------------------------------------------------------------------------
// Feed the bytes that follow a percent sign on char_stream, one byte per beat.
// Flags (+ space - 0 #) come first, then width digits, then an optional dot
// with precision digits, then an optional length modifier (h hh l ll L); the
// next byte is the conversion byte and closes the specifier. Any byte that is
// not legal where it stands is taken as the conversion byte. One spec_stream
// beat carries the flags (plus wins over space, minus wins over zero), width,
// precision (1 for a bare dot, 0 with no dot), modifier code and conversion
// byte; the parser then starts over. Width and precision saturate at
// 2^NUMBER_BITS - 1, capped at 65535. Throughput is one byte per clock: a
// byte sits in the input register while the phase logic and the
// multiply-by-ten-plus-digit update run, and a completed specifier appears on
// spec_stream the cycle after its conversion byte is processed. Bytes stall
// only when a specifier is ready to leave while the output register still
// holds one that the sink has not taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "format_spec_parser_assert.svh"

module format_spec_parser #(
    parameter int NUMBER_BITS = fsp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    fsp_char_if.sink        char_stream,
    fsp_spec_if.source      spec_stream
);

    // Input register
    logic                        s1_valid_reg;
    logic [fsp_pkg::CHAR_W-1:0]  s1_char_reg;

    // Result register
    logic                        out_valid_reg;
    fsp_pkg::spec_t              out_spec_reg;

    fsp_pkg::core_out_t          core_out;
    logic                        out_free;
    logic                        s1_go;
    logic                        char_take;

    fsp_core #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_go),
        .character (s1_char_reg),
        .core_out  (core_out)
    );

    // Result slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || spec_stream.ready;

    // Advance the held byte unless it closes a spec and the slot is busy
    assign s1_go     = s1_valid_reg && (!core_out.emit || out_free);

    assign char_stream.ready = !s1_valid_reg || s1_go;
    assign char_take         = char_stream.valid && char_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_take)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go && core_out.emit)
                out_valid_reg <= 1'b1;
            else if (spec_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on beat, no reset
    always_ff @(posedge clk)
    begin
        if (char_take)
            s1_char_reg <= char_stream.character;
        if (s1_go && core_out.emit)
            out_spec_reg <= core_out.spec;
    end

    assign spec_stream.valid           = out_valid_reg;
    assign spec_stream.flag_plus       = out_spec_reg.flag_plus;
    assign spec_stream.flag_space      = out_spec_reg.flag_space;
    assign spec_stream.flag_minus      = out_spec_reg.flag_minus;
    assign spec_stream.flag_zero       = out_spec_reg.flag_zero;
    assign spec_stream.flag_hash       = out_spec_reg.flag_hash;
    assign spec_stream.field_width     = out_spec_reg.field_width;
    assign spec_stream.has_precision   = out_spec_reg.has_precision;
    assign spec_stream.precision_value = out_spec_reg.precision_value;
    assign spec_stream.length_modifier = out_spec_reg.length_modifier;
    assign spec_stream.conversion      = out_spec_reg.conversion;

    // A closing byte that advances always lands in the result register
    `FSP_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, s1_go && core_out.emit, out_valid_reg)

    // Never overwrite a result the sink has not taken
    `FSP_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_reg && !spec_stream.ready, !(s1_go && core_out.emit))

    // Flag precedence holds on every delivered spec
    `FSP_ASSERT_NOW(a_flag_precedence, clk, rst_n, out_valid_reg, !(out_spec_reg.flag_plus && out_spec_reg.flag_space) && !(out_spec_reg.flag_minus && out_spec_reg.flag_zero))

    // No dot means precision reads zero
    `FSP_ASSERT_NOW(a_prec_without_dot, clk, rst_n, out_valid_reg && !out_spec_reg.has_precision, out_spec_reg.precision_value == '0)

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Format spec parser testbench
// Streams the bytes that follow a percent sign into the parser. A model of the
// parse phases inside the tracker class predicts each specifier, and every
// specifier beat from the parser is checked field by field. Both channels
// idle at random, and the sink also makes one long hold-off to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fsp_pkg::*;

    localparam int          NUMBER_BITS = NUMBER_BITS_DEFAULT;
    localparam int unsigned NUM_MAX     = ((1 << NUMBER_BITS) - 1) > 65535 ?
                                          65535 : ((1 << NUMBER_BITS) - 1);
    localparam int          RESET_CYCLES = 7;
    localparam int          TARGET_CHARS = 500;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          IDLE_LIMIT   = 2000;

    localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;

    // Parse phases of the prediction
    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_WIDTH,
        PH_DOT,
        PH_PREC,
        PH_MOD_H,
        PH_MOD_L,
        PH_MOD_DONE
    } parse_phase_t;

    // ------------------------------------------------------------------------
    // Tracker: parses the accepted bytes the way the block should, holds the
    // specifiers still owed by the block and checks each one that arrives.
    // ------------------------------------------------------------------------
    class spec_tracker;
        parse_phase_t         phase;
        logic [FLAG_W-1:0]    flags;
        logic [NUM_OUT_W-1:0] width_acc;
        logic                 dot_seen;
        logic [NUM_OUT_W-1:0] prec_acc;
        logic [MOD_W-1:0]     mod_code;
        spec_t                owed_specs[$];
        int                   errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = PH_FLAGS;
            flags     = '0;
            width_acc = '0;
            dot_seen  = 1'b0;
            prec_acc  = '0;
            mod_code  = MOD_NONE;
        endfunction

        function logic [NUM_OUT_W-1:0] add_digit(logic [NUM_OUT_W-1:0] acc,
                                                 logic [CHAR_W-1:0] c);
            int unsigned v;
            v = acc * 10 + (c - CHAR_ZERO);
            return (v > NUM_MAX) ? NUM_MAX[NUM_OUT_W-1:0] : v[NUM_OUT_W-1:0];
        endfunction

        // Close the specifier on its conversion byte.
        function void close_spec(logic [CHAR_W-1:0] c);
            spec_t s;
            logic [FLAG_W-1:0] f;
            f = flags;
            if (f[FB_PLUS])
                f[FB_SPACE] = 1'b0;
            if (f[FB_MINUS])
                f[FB_ZERO] = 1'b0;
            s.flag_plus       = f[FB_PLUS];
            s.flag_space      = f[FB_SPACE];
            s.flag_minus      = f[FB_MINUS];
            s.flag_zero       = f[FB_ZERO];
            s.flag_hash       = f[FB_HASH];
            s.field_width     = width_acc;
            s.has_precision   = dot_seen;
            s.precision_value = dot_seen ? prec_acc : '0;
            s.length_modifier = mod_code;
            s.conversion      = c;
            owed_specs.push_back(s);
            clear();
        endfunction

        // Start a modifier, or close on anything else.
        function void modifier_or_close(logic [CHAR_W-1:0] c);
            if (c == CHAR_LOW_H)
                phase = PH_MOD_H;
            else if (c == CHAR_LOW_L)
                phase = PH_MOD_L;
            else if (c == CHAR_UP_L)
            begin
                mod_code = MOD_BIGL;
                phase    = PH_MOD_DONE;
            end
            else
                close_spec(c);
        endfunction

        function void take_char(logic [CHAR_W-1:0] c);
            bit is_digit;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            case (phase)
                PH_FLAGS, PH_WIDTH:
                begin
                    // A zero before any width digit is a flag.
                    if (phase == PH_FLAGS && c == CHAR_PLUS)
                        flags[FB_PLUS] = 1'b1;
                    else if (phase == PH_FLAGS && c == CHAR_SPACE)
                        flags[FB_SPACE] = 1'b1;
                    else if (phase == PH_FLAGS && c == CHAR_MINUS)
                        flags[FB_MINUS] = 1'b1;
                    else if (phase == PH_FLAGS && c == CHAR_ZERO)
                        flags[FB_ZERO] = 1'b1;
                    else if (phase == PH_FLAGS && c == CHAR_HASH)
                        flags[FB_HASH] = 1'b1;
                    else if (is_digit)
                    begin
                        width_acc = add_digit(width_acc, c);
                        phase     = PH_WIDTH;
                    end
                    else if (c == CHAR_DOT)
                    begin
                        dot_seen = 1'b1;
                        prec_acc = NUM_OUT_W'(1);
                        phase    = PH_DOT;
                    end
                    else
                        modifier_or_close(c);
                end
                PH_DOT:
                begin
                    if (is_digit)
                    begin
                        prec_acc = NUM_OUT_W'(c - CHAR_ZERO);
                        phase    = PH_PREC;
                    end
                    else
                        modifier_or_close(c);
                end
                PH_PREC:
                begin
                    if (is_digit)
                        prec_acc = add_digit(prec_acc, c);
                    else
                        modifier_or_close(c);
                end
                PH_MOD_H:
                begin
                    if (c == CHAR_LOW_H)
                    begin
                        mod_code = MOD_HH;
                        phase    = PH_MOD_DONE;
                    end
                    else
                    begin
                        mod_code = MOD_H;
                        close_spec(c);
                    end
                end
                PH_MOD_L:
                begin
                    if (c == CHAR_LOW_L)
                    begin
                        mod_code = MOD_LL;
                        phase    = PH_MOD_DONE;
                    end
                    else
                    begin
                        mod_code = MOD_L;
                        close_spec(c);
                    end
                end
                default:
                    close_spec(c);
            endcase
        endfunction

        function void cmp(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_spec(spec_t got);
            spec_t want;
            if (owed_specs.size() == 0)
            begin
                $error("specifier beat with none expected: conversion %0d",
                       got.conversion);
                errors++;
                return;
            end
            want = owed_specs.pop_front();
            cmp("flag_plus", want.flag_plus, got.flag_plus);
            cmp("flag_space", want.flag_space, got.flag_space);
            cmp("flag_minus", want.flag_minus, got.flag_minus);
            cmp("flag_zero", want.flag_zero, got.flag_zero);
            cmp("flag_hash", want.flag_hash, got.flag_hash);
            cmp("field_width", want.field_width, got.field_width);
            cmp("has_precision", want.has_precision, got.has_precision);
            cmp("precision_value", want.precision_value, got.precision_value);
            cmp("length_modifier", want.length_modifier, got.length_modifier);
            cmp("conversion", want.conversion, got.conversion);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    fsp_char_if char_if ();
    fsp_spec_if spec_if ();

    format_spec_parser #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .spec_stream (spec_if)
    );

    spec_tracker tracker;

    // Set by the stimulus to ask the sink for its one long hold-off.
    logic hold_off_req;
    // Calm windows in which neither side idles.
    logic calm;
    bit   burst_on;
    int   chars_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build the tracker and hold reset, then release it.
    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Gap length: mostly none or short, now and then long; none when calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Alternate long busy windows with short calm ones.
    initial
    begin
        calm <= 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 400)) @(posedge clk);
            calm <= 1'b1;
            repeat ($urandom_range(30, 80)) @(posedge clk);
            calm <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Sink side: check each accepted specifier beat, then decide ready.
    // ------------------------------------------------------------------------
    initial
    begin
        spec_t got;
        int    stall_left;
        int    hold_left;
        bit    hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        spec_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (spec_if.valid && spec_if.ready)
            begin
                got.flag_plus       = spec_if.flag_plus;
                got.flag_space      = spec_if.flag_space;
                got.flag_minus      = spec_if.flag_minus;
                got.flag_zero       = spec_if.flag_zero;
                got.flag_hash       = spec_if.flag_hash;
                got.field_width     = spec_if.field_width;
                got.has_precision   = spec_if.has_precision;
                got.precision_value = spec_if.precision_value;
                got.length_modifier = spec_if.length_modifier;
                got.conversion      = spec_if.conversion;
                tracker.check_spec(got);
            end
            // Exactly one assignment to ready per edge.
            if (hold_left > 0)
            begin
                hold_left--;
                spec_if.ready <= 1'b0;
            end
            else if (hold_off_req && !hold_done)
            begin
                // Hold off long enough for the block to fill and stall.
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                spec_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                spec_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    stall_left--;
                    spec_if.ready <= 1'b0;
                end
                else
                    spec_if.ready <= 1'b1;
            end
        end
    end

    // Stop the run if nothing moves on either channel for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((char_if.valid && char_if.ready) || (spec_if.valid && spec_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("** format_spec_parser: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------

    // Offer one byte, with an optional gap before it, and hold it until taken.
    task automatic send_char(logic [CHAR_W-1:0] c);
        int g;
        g = burst_on ? 0 : pick_gap();
        if (g > 0)
        begin
            char_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.character <= c;
        do
            @(posedge clk);
        while (!char_if.ready);
        tracker.take_char(c);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_digits(int n);
        for (int i = 0; i < n; i++)
            send_char(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    // One well-formed specifier with random content; the conversion is
    // sometimes an arbitrary byte, which may itself continue the parse.
    task automatic send_random_spec();
        string  flag_set;
        string  conv_set;
        int     r;
        flag_set = "+ -0#";
        conv_set = "diouxXfFeEgGaAcspn%";
        repeat ($urandom_range(0, 3))
            send_char(flag_set[$urandom_range(0, 4)]);
        r = $urandom_range(0, 99);
        if (r >= 50)
            send_digits((r >= 95) ? $urandom_range(5, 6) : $urandom_range(1, 3));
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            send_char(CHAR_DOT);
            send_digits((r < 3) ? $urandom_range(5, 6) : $urandom_range(0, 3));
        end
        r = $urandom_range(0, 9);
        case (r)
            0: send_char(CHAR_LOW_H);
            1: send_text("hh");
            2: send_char(CHAR_LOW_L);
            3: send_text("ll");
            4: send_char(CHAR_UP_L);
            default: ;
        endcase
        if ($urandom_range(0, 99) < 80)
            send_char(conv_set[$urandom_range(0, conv_set.len() - 1)]);
        else
            send_char(CHAR_W'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit hold_started;
        burst_on     = 1'b0;
        chars_sent   = 0;
        hold_started = 1'b0;
        hold_off_req      <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.character <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed: every flag with both overrides and a percent conversion.
        send_text("+ -0#%");
        // Saturated width with a zero after a nonzero digit, bare dot, single h.
        send_text("70000.hi");
        // Precision with leading zeros, ll, then a byte after a full modifier.
        send_text(".0099lll");
        // Flag after width digits closes the specifier.
        send_text("5+");
        // Big L modifier, then a NUL conversion.
        send_char(CHAR_UP_L);
        send_char(8'h00);
        // Single l closed by an all-ones byte.
        send_char(CHAR_LOW_L);
        send_char(8'hFF);
        // hh followed by a dot, which must close the specifier.
        send_text("hh.");

        // Random: mostly well-formed specifiers, some plain noise.
        while (chars_sent < TARGET_CHARS)
        begin
            if (!hold_started && chars_sent >= 150)
            begin
                // Keep offering back-to-back while the sink holds off.
                hold_started = 1'b1;
                hold_off_req <= 1'b1;
                burst_on     = 1'b1;
                repeat (30) send_random_spec();
                burst_on     = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4)) send_char(CHAR_W'($urandom_range(0, 255)));
            else
                send_random_spec();
        end
        // Close any open specifier so the tail is checked too.
        send_char(CHAR_PERCENT);
        char_if.valid <= 1'b0;

        // Drain: wait for every owed specifier, then let the channels settle.
        while (tracker.owed_specs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.owed_specs.size() == 0)
            $display("** format_spec_parser: PASSED **");
        else
            $display("** format_spec_parser: FAILED **");
        $finish;
    end

endmodule
